/* rtl/core/cdq_pkg.sv */
// cdq_pkg: shared constants for the circular double-ended queue
// operation and status codes, default sizes
// no dependencies
package cdq_pkg;

  // default sizes
  localparam int CDQ_DEPTH      = 256;
  localparam int CDQ_DATA_WIDTH = 32;

  // command codes
  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_BACK   = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;
  localparam logic [2:0] OP_RESIZE     = 3'd6;

  // result status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_EMPTY  = 3'd2;
  localparam logic [2:0] ST_RANGE  = 3'd3;
  localparam logic [2:0] ST_TOOBIG = 3'd4;

endpackage

/* rtl/core/cdq_ram.sv */
// cdq_ram: generic single-write, single-read synchronous RAM
// read data is registered
// no dependencies
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/circular_double_ended_queue.sv */
// circular_double_ended_queue: fixed-capacity ring-buffer deque
// depends on cdq_pkg and cdq_ram
//
// Usage: one request on the input channel (operation, value, position,
// new_length) gives exactly one result on the output channel (status,
// read_value, front_value, back_value, entry_count, is_empty). Both
// channels use valid/stall; a request is taken when in_valid is high and
// in_stall is low.
// Timing: requests are handled one at a time. The block takes a request,
// executes it in the next cycle (S_EXEC) and loads the output register from
// S_DONE as soon as that register is free.
// Requests that read no RAM entry (pushes, clear, failed commands, resize
// to the same length, pops or shrinks that empty the deque) go from S_EXEC
// straight to S_DONE; a pop or shrink that leaves entries and a good read
// pass through S_WAIT, since the new front, back or read entry comes out
// of the element RAM's registered read port. A growing resize writes one
// appended entry per cycle through the single RAM write port, in S_EXEC
// and then in S_GROW.
// The front and back entries are held in registers so that every result
// reports them without an extra RAM read.
// Reset clears the pointers and the count; the RAM is not cleared, since
// only slots covered by the count are ever read.
// When the receiver stalls, a finished result waits in the output register
// and the next request may already be taken and executed; its result is
// held back until the output register is free.
module circular_double_ended_queue
  import cdq_pkg::*;
#(
  parameter int DEPTH      = CDQ_DEPTH,
  parameter int DATA_WIDTH = CDQ_DATA_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         operation,
  input  logic signed [31:0] value,
  input  logic [7:0]         position,
  input  logic [8:0]         new_length,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [31:0] read_value,
  output logic signed [31:0] front_value,
  output logic signed [31:0] back_value,
  output logic [8:0]         entry_count,
  output logic               is_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > 9) ? CW : 9;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_S   = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_GROW = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // what the pending ram read fills in
  localparam logic [1:0] CAP_BACK  = 2'd0;
  localparam logic [1:0] CAP_FRONT = 2'd1;
  localparam logic [1:0] CAP_READ  = 2'd2;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST_SLOT : p - 1'b1;
  endfunction

  // add two slot offsets below DEPTH, wrapping once
  function automatic logic [AW-1:0] wrap_add(input logic [AW:0] s);
    logic [AW:0] r;
    r = (s >= DEPTH_S) ? s - DEPTH_S : s;
    return r[AW-1:0];
  endfunction

  // sign-extend a stored entry and cut it to the 32-bit result width
  function automatic logic [31:0] to_out(input logic [DATA_WIDTH-1:0] d);
    logic [63:0] w;
    w = 64'($signed(d));
    return w[31:0];
  endfunction

  // registers
  logic [2:0]            state, state_next;
  logic [2:0]            cmd_op;
  logic [31:0]           cmd_val;
  logic [7:0]            cmd_pos;
  logic [8:0]            cmd_len;
  logic [AW-1:0]         head, head_next;
  logic [AW-1:0]         tail, tail_next;
  logic [CW-1:0]         count, count_next;
  logic [DATA_WIDTH-1:0] front, front_next;
  logic [DATA_WIDTH-1:0] back, back_next;
  logic [31:0]           rd_val, rd_val_next;
  logic [2:0]            res_status, res_status_next;
  logic [1:0]            cap_sel, cap_sel_next;

  // ram ports
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // derived values
  logic [DATA_WIDTH-1:0] store_val;
  logic [LW-1:0]         count_l;
  logic [LW-1:0]         len_l;
  logic [LW-1:0]         pos_l;
  logic [AW-1:0]         back_slot;
  logic [AW-1:0]         front_slot;
  logic                  load_out;

  assign store_val  = DATA_WIDTH'(cmd_val);
  assign count_l    = LW'(count);
  assign len_l      = LW'(cmd_len);
  assign pos_l      = LW'(cmd_pos);
  assign back_slot  = (count == '0) ? '0 : wrap_inc(tail);
  assign front_slot = (count == '0) ? '0 : wrap_dec(head);
  assign in_stall   = (state != S_IDLE);
  assign load_out   = (state == S_DONE) && (!out_valid || !out_stall);

  cdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (store_val),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // command sequencer
  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    front_next      = front;
    back_next       = back;
    rd_val_next     = rd_val;
    res_status_next = res_status;
    cap_sel_next    = cap_sel;
    ram_we          = 1'b0;
    ram_waddr       = back_slot;
    ram_raddr       = tail;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        res_status_next = ST_OK;
        rd_val_next     = '0;
        state_next      = S_DONE;
        unique case (cmd_op)
          OP_PUSH_BACK: begin
            if (count == FULL_CNT) begin
              res_status_next = ST_FULL;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = back_slot;
              head_next  = (count == '0) ? '0 : head;
              tail_next  = back_slot;
              count_next = count + 1'b1;
              back_next  = store_val;
              if (count == '0) begin
                front_next = store_val;
              end
            end
          end

          OP_PUSH_FRONT: begin
            if (count == FULL_CNT) begin
              res_status_next = ST_FULL;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = front_slot;
              head_next  = front_slot;
              tail_next  = (count == '0) ? '0 : tail;
              count_next = count + 1'b1;
              front_next = store_val;
              if (count == '0) begin
                back_next = store_val;
              end
            end
          end

          OP_POP_BACK: begin
            if (count == '0) begin
              res_status_next = ST_EMPTY;
            end else begin
              count_next = count - 1'b1;
              if (count == CW'(1)) begin
                head_next = '0;
                tail_next = '0;
              end else begin
                tail_next    = wrap_dec(tail);
                ram_raddr    = wrap_dec(tail);
                cap_sel_next = CAP_BACK;
                state_next   = S_WAIT;
              end
            end
          end

          OP_POP_FRONT: begin
            if (count == '0) begin
              res_status_next = ST_EMPTY;
            end else begin
              count_next = count - 1'b1;
              if (count == CW'(1)) begin
                head_next = '0;
                tail_next = '0;
              end else begin
                head_next    = wrap_inc(head);
                ram_raddr    = wrap_inc(head);
                cap_sel_next = CAP_FRONT;
                state_next   = S_WAIT;
              end
            end
          end

          OP_READ: begin
            if (count == '0) begin
              res_status_next = ST_EMPTY;
            end else if (pos_l >= count_l) begin
              res_status_next = ST_RANGE;
            end else begin
              ram_raddr    = wrap_add((AW + 1)'(head) + (AW + 1)'(cmd_pos));
              cap_sel_next = CAP_READ;
              state_next   = S_WAIT;
            end
          end

          OP_CLEAR: begin
            count_next = '0;
            head_next  = '0;
            tail_next  = '0;
          end

          OP_RESIZE: begin
            if (32'(cmd_len) > 32'(DEPTH)) begin
              res_status_next = ST_TOOBIG;
            end else if (len_l > count_l) begin
              // first appended entry now, the rest one per cycle
              ram_we     = 1'b1;
              ram_waddr  = back_slot;
              head_next  = (count == '0) ? '0 : head;
              tail_next  = back_slot;
              count_next = count + 1'b1;
              back_next  = store_val;
              if (count == '0) begin
                front_next = store_val;
              end
              if (len_l != count_l + 1'b1) begin
                state_next = S_GROW;
              end
            end else if (len_l < count_l) begin
              count_next = CW'(cmd_len);
              if (cmd_len == '0) begin
                head_next = '0;
                tail_next = '0;
              end else begin
                // new back sits at head + length - 1
                tail_next    = wrap_add((AW + 1)'(head) + (AW + 1)'(cmd_len - 9'd1));
                ram_raddr    = wrap_add((AW + 1)'(head) + (AW + 1)'(cmd_len - 9'd1));
                cap_sel_next = CAP_BACK;
                state_next   = S_WAIT;
              end
            end
          end

          default: begin
          end
        endcase
      end

      S_GROW: begin
        ram_we     = 1'b1;
        ram_waddr  = back_slot;
        tail_next  = back_slot;
        count_next = count + 1'b1;
        back_next  = store_val;
        if (len_l == count_l + 1'b1) begin
          state_next = S_DONE;
        end
      end

      S_WAIT: begin
        case (cap_sel)
          CAP_FRONT: front_next  = ram_rdata;
          CAP_READ:  rd_val_next = to_out(ram_rdata);
          default:   back_next   = ram_rdata;
        endcase
        state_next = S_DONE;
      end

      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request latch and working payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd_op  <= operation;
      cmd_val <= $unsigned(value);
      cmd_pos <= position;
      cmd_len <= new_length;
    end
    front      <= front_next;
    back       <= back_next;
    rd_val     <= rd_val_next;
    res_status <= res_status_next;
    cap_sel    <= cap_sel_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      status      <= res_status;
      read_value  <= $signed(rd_val);
      front_value <= (count == '0) ? '0 : $signed(to_out(front));
      back_value  <= (count == '0) ? '0 : $signed(to_out(back));
      entry_count <= 9'(count);
      is_empty    <= (count == '0);
    end
  end

endmodule

/* bench/circular_double_ended_queue_tb.sv */
// circular_double_ended_queue_tb: self-checking bench for the ring-buffer deque
// directed corner requests, then mode-shaped random traffic under random stalls
// depends on cdq_pkg and circular_double_ended_queue
`timescale 1ns / 1ps

module circular_double_ended_queue_tb;
  import cdq_pkg::*;

  localparam int DEPTH           = CDQ_DEPTH;
  localparam int RANDOM_REQUESTS = 1600;
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int SETTLE_CYCLES   = 300;
  // code with no command behind it; the block reports its contents unchanged
  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_value;
    logic [31:0] front_value;
    logic [31:0] back_value;
    logic [8:0]  entry_count;
    logic        is_empty;
  } deque_result_t;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_NOISE} traffic_mode_t;

  // deque predictor plus queue of expected results
  class deque_scoreboard;
    logic [31:0]   slots [DEPTH];
    bit [7:0]      head;
    bit [7:0]      tail;
    bit [8:0]      count;
    deque_result_t expected_q [$];
    int            errors;

    function bit append_back(logic [31:0] v);
      if (count == DEPTH) return 0;
      if (count == 0) begin
        head = 0;
        tail = 0;
      end else begin
        tail = tail + 8'd1;
      end
      slots[tail] = v;
      count++;
      return 1;
    endfunction

    function bit remove_back();
      if (count == 0) return 0;
      count--;
      if (count == 0) begin
        head = 0;
        tail = 0;
      end else begin
        tail = tail - 8'd1;
      end
      return 1;
    endfunction

    // apply one accepted request and queue the result it must produce
    function void note_request(bit [2:0] op, logic [31:0] val, bit [7:0] pos,
                               bit [8:0] len);
      deque_result_t r;
      bit [7:0] slot;
      r = '0;
      r.status = ST_OK;
      case (op)
        OP_PUSH_BACK: if (!append_back(val)) r.status = ST_FULL;
        OP_PUSH_FRONT: begin
          if (count == DEPTH) r.status = ST_FULL;
          else begin
            if (count == 0) begin
              head = 0;
              tail = 0;
            end else begin
              head = head - 8'd1;
            end
            slots[head] = val;
            count++;
          end
        end
        OP_POP_BACK: if (!remove_back()) r.status = ST_EMPTY;
        OP_POP_FRONT: begin
          if (count == 0) r.status = ST_EMPTY;
          else begin
            count--;
            if (count == 0) begin
              head = 0;
              tail = 0;
            end else begin
              head = head + 8'd1;
            end
          end
        end
        OP_READ: begin
          if (count == 0) r.status = ST_EMPTY;
          else if (pos >= count) r.status = ST_RANGE;
          else begin
            slot = head + pos;
            r.read_value = slots[slot];
          end
        end
        OP_CLEAR: begin
          count = 0;
          head = 0;
          tail = 0;
        end
        OP_RESIZE: begin
          if (len > DEPTH) r.status = ST_TOOBIG;
          else begin
            while (count < len) void'(append_back(val));
            while (count > len) void'(remove_back());
          end
        end
        default: ;
      endcase
      r.front_value = (count != 0) ? slots[head] : 32'd0;
      r.back_value  = (count != 0) ? slots[tail] : 32'd0;
      r.entry_count = count;
      r.is_empty    = (count == 0);
      expected_q = {expected_q, r};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s expected 0x%08h got 0x%08h", name, want, got);
        errors++;
      end
    endfunction

    // match an accepted result against the oldest expectation
    function void check_result(deque_result_t got);
      deque_result_t want;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      want = expected_q[0];
      expected_q.delete(0);
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("read_value", want.read_value, got.read_value);
      compare_field("front_value", want.front_value, got.front_value);
      compare_field("back_value", want.back_value, got.back_value);
      compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
      compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic [2:0]         operation  = '0;
  logic signed [31:0] value      = '0;
  logic [7:0]         position   = '0;
  logic [8:0]         new_length = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic [2:0]         status;
  logic signed [31:0] read_value;
  logic signed [31:0] front_value;
  logic signed [31:0] back_value;
  logic [8:0]         entry_count;
  logic               is_empty;

  deque_scoreboard sb;
  int              quiet_left  = 0;
  int              stall_left  = 0;
  bit              stall_mode  = 1'b0;
  int              cycle_count = 0;
  logic [31:0]     corner_values [4] = '{32'h0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000};

  circular_double_ended_queue u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .value       (value),
    .position    (position),
    .new_length  (new_length),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .read_value  (read_value),
    .front_value (front_value),
    .back_value  (back_value),
    .entry_count (entry_count),
    .is_empty    (is_empty)
  );

  always #1 clk = ~clk;

  // idle length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  // result side: check accepted results, stall in random bursts
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result({status, read_value, front_value, back_value, entry_count, is_empty});
    if (stall_left == 0) begin
      stall_mode = ($urandom_range(0, 2) == 0);
      stall_left = stall_mode ? pick_gap() : $urandom_range(1, 40);
    end
    stall_left--;
    out_stall <= stall_mode;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // present one request, hold it until taken, then predict its result
  task automatic send_request(bit [2:0] op, logic [31:0] val, bit [7:0] pos,
                              bit [8:0] len);
    int gap;
    gap = 0;
    if (quiet_left > 0) quiet_left--;
    else if ($urandom_range(0, 19) == 0) quiet_left = $urandom_range(10, 60);
    else if ($urandom_range(0, 1) == 0) gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    value      <= val;
    position   <= pos;
    new_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, val, pos, len);
  endtask

  // hold off the request side until every result is back
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    @(posedge clk);
  endtask

  // one random request shaped by the current traffic mode
  task automatic send_random(traffic_mode_t mode);
    int          r;
    int          grow;
    bit [2:0]    op;
    logic [31:0] val;
    bit [7:0]    pos;
    bit [8:0]    len;
    val = ($urandom_range(0, 9) == 0) ? corner_values[$urandom_range(0, 3)] : $urandom;
    if (sb.count == 0 || $urandom_range(0, 9) == 0) pos = 8'($urandom_range(0, 255));
    else pos = 8'($urandom_range(0, (sb.count > 255) ? 255 : sb.count));
    r = $urandom_range(0, 99);
    grow = sb.count + $urandom_range(0, 24);
    if (mode == MODE_NOISE || r < 5) len = 9'($urandom_range(0, 511));
    else if (mode == MODE_DRAIN || r < 45) len = 9'($urandom_range(0, sb.count));
    else if (r < 55) len = 9'(DEPTH);
    else len = 9'((grow > DEPTH) ? DEPTH : grow);
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:
        op = (r < 45) ? OP_PUSH_BACK : (r < 85) ? OP_PUSH_FRONT : (r < 90) ? OP_READ :
             (r < 95) ? OP_POP_FRONT : OP_RESIZE;
      MODE_DRAIN:
        op = (r < 40) ? OP_POP_BACK : (r < 80) ? OP_POP_FRONT : (r < 90) ? OP_READ :
             (r < 95) ? OP_PUSH_BACK : (r < 97) ? OP_CLEAR : OP_RESIZE;
      MODE_MIXED:
        op = (r < 40) ? OP_READ : (r < 52) ? OP_PUSH_BACK : (r < 64) ? OP_PUSH_FRONT :
             (r < 76) ? OP_POP_BACK : (r < 88) ? OP_POP_FRONT : (r < 94) ? OP_RESIZE :
             (r < 97) ? OP_CLEAR : OP_UNUSED;
      default: op = 3'($urandom_range(0, 7));
    endcase
    send_request(op, val, pos, len);
  endtask

  initial begin
    traffic_mode_t mode;
    int            mode_left;
    mode = MODE_FILL;
    mode_left = 0;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty deque corners
    send_request(OP_POP_BACK, 32'h0, 8'd0, 9'd0);
    send_request(OP_POP_FRONT, 32'h0, 8'd0, 9'd0);
    send_request(OP_READ, 32'h0, 8'd0, 9'd0);
    send_request(OP_RESIZE, 32'h1234_5678, 8'd0, 9'd0);
    send_request(OP_UNUSED, 32'hffff_ffff, 8'd255, 9'd511);
    // pushes at both ends, front push wraps the head
    send_request(OP_PUSH_BACK, 32'h7fff_ffff, 8'd0, 9'd0);
    send_request(OP_PUSH_FRONT, 32'h8000_0000, 8'd0, 9'd0);
    send_request(OP_PUSH_BACK, 32'h0, 8'd0, 9'd0);
    send_request(OP_PUSH_FRONT, 32'hffff_ffff, 8'd0, 9'd0);
    // reads in range, at the count and far past it
    send_request(OP_READ, 32'h0, 8'd0, 9'd0);
    send_request(OP_READ, 32'h0, 8'd3, 9'd0);
    send_request(OP_READ, 32'h0, 8'd4, 9'd0);
    send_request(OP_READ, 32'h0, 8'd255, 9'd0);
    send_request(OP_POP_BACK, 32'h0, 8'd0, 9'd0);
    send_request(OP_POP_FRONT, 32'h0, 8'd0, 9'd0);
    // resize above capacity is refused
    send_request(OP_RESIZE, 32'h0, 8'd0, 9'd300);
    send_request(OP_RESIZE, 32'hffff_ffff, 8'd0, 9'd511);
    // fill to capacity, then overflow at both ends
    send_request(OP_RESIZE, 32'h5555_5555, 8'd0, 9'(DEPTH));
    send_request(OP_PUSH_BACK, 32'h1111_1111, 8'd0, 9'd0);
    send_request(OP_PUSH_FRONT, 32'h2222_2222, 8'd0, 9'd0);
    send_request(OP_READ, 32'h0, 8'd255, 9'd0);
    send_request(OP_UNUSED, 32'h0, 8'd0, 9'd0);
    send_request(OP_RESIZE, 32'h0, 8'd0, 9'(DEPTH));
    // shrink, clear, grow from empty
    send_request(OP_RESIZE, 32'h0, 8'd0, 9'd5);
    send_request(OP_CLEAR, 32'h0, 8'd0, 9'd0);
    send_request(OP_RESIZE, 32'haaaa_aaaa, 8'd0, 9'd3);
    pause_until_drained();

    // random traffic in changing modes
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == RANDOM_REQUESTS / 2) pause_until_drained();
      if (mode_left == 0) begin
        mode = traffic_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      send_random(mode);
    end

    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
